/* rtl/core/esa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package esa_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned SEL_W  = 16;
	localparam int unsigned CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_BORROW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RETURN  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_QUERY,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic exec;
		logic query_load;
		logic scan_step;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic [CMD_W-1:0] cmd_code;
		logic             hit;
		logic             exhausted;
		logic             out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/esa_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface esa_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [esa_pkg::CMD_W-1:0]       cmd;
	logic [esa_pkg::TIME_W-1:0]      now_time;
	logic [esa_pkg::SEL_W-1:0]       slot_select;

	modport source (output valid, output cmd, output now_time, output slot_select,
		input ready);
	modport sink (input valid, input cmd, input now_time, input slot_select,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/esa_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface esa_res_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [esa_pkg::SEL_W-1:0]       slot_index;
	logic                            reclaimed;
	logic [esa_pkg::TIME_W-1:0]      stamp_time;

	modport source (output valid, output ok, output slot_index, output reclaimed,
		output stamp_time, input ready);
	modport sink (input valid, input ok, input slot_index, input reclaimed,
		input stamp_time, output ready);
endinterface

`default_nettype wire

/* rtl/core/esa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module esa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire esa_pkg::dp_status_t stat,
	output esa_pkg::ctrl_cmd_t       ctl
);

	esa_pkg::ctrl_state_t state_q;
	esa_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			esa_pkg::ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = esa_pkg::ST_IDLE;
				end
			end
			esa_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				ctl.accept = req_valid;
				if (req_valid) begin
					state_d = esa_pkg::ST_EXEC;
				end
			end
			esa_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				case (stat.cmd_code)
					esa_pkg::CMD_BORROW: state_d = esa_pkg::ST_SCAN;
					esa_pkg::CMD_QUERY:  state_d = esa_pkg::ST_QUERY;
					default:             state_d = esa_pkg::ST_DONE;
				endcase
			end
			esa_pkg::ST_QUERY: begin
				ctl.query_load = 1'b1;
				state_d        = esa_pkg::ST_DONE;
			end
			esa_pkg::ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (stat.hit || stat.exhausted) begin
					state_d = esa_pkg::ST_DONE;
				end
			end
			esa_pkg::ST_DONE: begin
				if (stat.out_free) begin
					ctl.publish = 1'b1;
					state_d     = esa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = esa_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/esa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module esa_dp #(
	parameter int unsigned POOL_SIZE = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [esa_pkg::TIME_W-1:0]        cfg_wdata,
	input  wire logic [esa_pkg::CMD_W-1:0]         req_cmd,
	input  wire logic [esa_pkg::TIME_W-1:0]        req_now_time,
	input  wire logic [esa_pkg::SEL_W-1:0]         req_slot_select,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output logic                                   rsp_ok,
	output logic [esa_pkg::SEL_W-1:0]              rsp_slot_index,
	output logic                                   rsp_reclaimed,
	output logic [esa_pkg::TIME_W-1:0]             rsp_stamp_time,
	input  wire esa_pkg::ctrl_cmd_t                ctl,
	output esa_pkg::dp_status_t                    stat
);

	localparam int unsigned IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int unsigned WORD_W = esa_pkg::TIME_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);
	localparam logic [esa_pkg::SEL_W:0] POOL_LIMIT = (esa_pkg::SEL_W + 1)'(POOL_SIZE);

	logic [WORD_W-1:0] mem_q [POOL_SIZE];

	logic [esa_pkg::TIME_W-1:0] expiry_age_q;
	logic [esa_pkg::CMD_W-1:0]  cmd_q;
	logic [esa_pkg::TIME_W-1:0] now_q;
	logic [IDX_W-1:0]           sel_idx_q;
	logic                       in_range_q;
	logic [esa_pkg::TIME_W-1:0] thr_q;
	logic                       thr_ok_q;

	logic [IDX_W-1:0]  clr_ptr_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]  ev_cnt_q;
	logic [IDX_W-1:0]  scan_start_q;
	logic [IDX_W-1:0]  ev_ptr_s1;
	logic [WORD_W-1:0] rd_data_s1;

	logic                       pend_ok_q;
	logic [esa_pkg::SEL_W-1:0]  pend_idx_q;
	logic                       pend_recl_q;
	logic [esa_pkg::TIME_W-1:0] pend_stamp_q;

	logic                       out_vld_q;
	logic                       out_ok_q;
	logic [esa_pkg::SEL_W-1:0]  out_idx_q;
	logic                       out_recl_q;
	logic [esa_pkg::TIME_W-1:0] out_stamp_q;

	logic              hit;
	logic              exhausted;
	logic              out_free;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		r = (p == LAST_IDX) ? '0 : p + IDX_W'(1);
		return r;
	endfunction

	assign hit = !rd_data_s1[WORD_W-1]
		|| (thr_ok_q && (thr_q > rd_data_s1[esa_pkg::TIME_W-1:0]));
	assign exhausted = (ev_cnt_q == LAST_IDX);
	assign out_free  = !out_vld_q || rsp_ready;

	always_comb begin
		stat.clr_last  = (clr_ptr_q == LAST_IDX);
		stat.cmd_code  = cmd_q;
		stat.hit       = hit;
		stat.exhausted = exhausted;
		stat.out_free  = out_free;
	end

	// write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sel_idx_q;
		wr_data = {1'b1, now_q};
		if (ctl.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q;
			wr_data = '0;
		end else if (ctl.exec && in_range_q && (cmd_q == esa_pkg::CMD_REFRESH)) begin
			wr_en = 1'b1;
		end else if (ctl.exec && in_range_q && (cmd_q == esa_pkg::CMD_RETURN)) begin
			wr_en   = 1'b1;
			wr_data = {1'b0, now_q};
		end else if (ctl.scan_step && hit) begin
			wr_en   = 1'b1;
			wr_addr = ev_ptr_s1;
		end
	end

	always_comb begin
		if (ctl.scan_step) begin
			rd_addr = rd_ptr_q;
		end else if (cmd_q == esa_pkg::CMD_QUERY) begin
			rd_addr = sel_idx_q;
		end else begin
			rd_addr = scan_start_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_age_q <= '0;
		end else if (cfg_we) begin
			expiry_age_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q      <= req_cmd;
			now_q      <= req_now_time;
			sel_idx_q  <= req_slot_select[IDX_W-1:0];
			in_range_q <= ({1'b0, req_slot_select} < POOL_LIMIT);
			thr_q      <= req_now_time - expiry_age_q;
			thr_ok_q   <= (req_now_time >= expiry_age_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q    <= '0;
			scan_start_q <= '0;
		end else begin
			if (ctl.clr_wr) begin
				clr_ptr_q <= next_idx(clr_ptr_q);
			end
			if (ctl.scan_step && hit) begin
				scan_start_q <= ev_ptr_s1;
			end
		end
	end

	// scan pointers: read one slot ahead of the one being judged
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rd_ptr_q  <= next_idx(scan_start_q);
			ev_ptr_s1 <= scan_start_q;
			ev_cnt_q  <= '0;
		end else if (ctl.scan_step) begin
			rd_ptr_q  <= next_idx(rd_ptr_q);
			ev_ptr_s1 <= rd_ptr_q;
			ev_cnt_q  <= ev_cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			pend_ok_q    <= 1'b0;
			pend_idx_q   <= '0;
			pend_recl_q  <= 1'b0;
			pend_stamp_q <= '0;
		end else if (ctl.query_load) begin
			pend_ok_q    <= in_range_q && rd_data_s1[WORD_W-1];
			pend_stamp_q <= (in_range_q && rd_data_s1[WORD_W-1])
				? rd_data_s1[esa_pkg::TIME_W-1:0] : '0;
		end else if (ctl.scan_step && hit) begin
			pend_ok_q   <= 1'b1;
			pend_idx_q  <= esa_pkg::SEL_W'(ev_ptr_s1);
			pend_recl_q <= rd_data_s1[WORD_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.publish) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			out_ok_q    <= pend_ok_q;
			out_idx_q   <= pend_idx_q;
			out_recl_q  <= pend_recl_q;
			out_stamp_q <= pend_stamp_q;
		end
	end

	assign rsp_valid      = out_vld_q;
	assign rsp_ok         = out_ok_q;
	assign rsp_slot_index = out_idx_q;
	assign rsp_reclaimed  = out_recl_q;
	assign rsp_stamp_time = out_stamp_q;

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> out_free)
		else $error("result published over an untaken word");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |=> out_vld_q)
		else $error("published word not shown");

	a_reclaim_expired: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan_step && hit && rd_data_s1[WORD_W-1]) |-> thr_ok_q)
		else $error("young slot reclaimed");

	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(scan_start_q) < POOL_SIZE))
		else $error("scan start beyond pool");

endmodule

`default_nettype wire

/* rtl/core/expiring_slot_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake    word
// req       in   valid/ready  cmd, now_time, slot_select
// rsp       out  valid/ready  ok, slot_index, reclaimed, stamp_time
// cfg       in   cfg_we       cfg_wdata (expiry_age)
//
// Refresh and return pass through EXEC and DONE after accept; query adds QUERY.
// Borrow scans in SCAN, examining k slots (1 to POOL_SIZE), one per
// cycle through the single read port of the slot memory.
// After reset a clearing pass frees every slot; req is
// not ready meanwhile. One word is in work at a time; a finished result waits
// in the output register while the next word is accepted.

module expiring_slot_allocator_top #(
	parameter int unsigned POOL_SIZE = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [esa_pkg::TIME_W-1:0] cfg_wdata,
	esa_cmd_if.sink                         req,
	esa_res_if.source                       rsp
);

	esa_pkg::ctrl_cmd_t  ctl;
	esa_pkg::dp_status_t stat;

	esa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	esa_dp #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req_cmd         (req.cmd),
		.req_now_time    (req.now_time),
		.req_slot_select (req.slot_select),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_ok          (rsp.ok),
		.rsp_slot_index  (rsp.slot_index),
		.rsp_reclaimed   (rsp.reclaimed),
		.rsp_stamp_time  (rsp.stamp_time),
		.ctl             (ctl),
		.stat            (stat)
	);

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned POOL_SLOTS = 1024;
	localparam logic [esa_pkg::TIME_W-1:0] STAMP_TOP = '1;
	localparam logic [esa_pkg::SEL_W-1:0] SEL_TOP = '1;
	localparam logic [esa_pkg::SEL_W-1:0] LAST_SLOT = esa_pkg::SEL_W'(POOL_SLOTS - 1);
	localparam logic [esa_pkg::SEL_W-1:0] PAST_LAST = esa_pkg::SEL_W'(POOL_SLOTS);

	typedef struct packed {
		logic [esa_pkg::CMD_W-1:0]  cmd;
		logic [esa_pkg::TIME_W-1:0] now_time;
		logic [esa_pkg::SEL_W-1:0]  slot_select;
	} pool_word_t;

	typedef struct packed {
		logic                       ok;
		logic [esa_pkg::SEL_W-1:0]  slot_index;
		logic                       reclaimed;
		logic [esa_pkg::TIME_W-1:0] stamp_time;
	} pool_reply_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [esa_pkg::TIME_W-1:0] cfg_wdata;

	esa_cmd_if req_ch ();
	esa_res_if rsp_ch ();

	expiring_slot_allocator_top #(.POOL_SIZE(POOL_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pool mirror
	logic [esa_pkg::TIME_W-1:0] slot_stamp [POOL_SLOTS];
	logic                       slot_used  [POOL_SLOTS];
	int unsigned                scan_from;
	logic [esa_pkg::TIME_W-1:0] expiry_age;

	pool_word_t  words_pending [$];
	pool_reply_t replies_due [$];
	int          mismatch_count = 0;

	function automatic pool_reply_t pool_response(input logic [esa_pkg::CMD_W-1:0] cmd,
		input logic [esa_pkg::TIME_W-1:0] now, input logic [esa_pkg::SEL_W-1:0] sel);
		pool_reply_t reply;
		int unsigned n;
		reply = '0;
		case (cmd)
			esa_pkg::CMD_BORROW: begin
				n = scan_from;
				for (int k = 0; k < POOL_SLOTS; k++) begin
					if (!slot_used[n] ||
						(now >= expiry_age && now - expiry_age > slot_stamp[n])) begin
						reply.ok = 1'b1;
						reply.slot_index = esa_pkg::SEL_W'(n);
						reply.reclaimed = slot_used[n];
						slot_used[n] = 1'b1;
						slot_stamp[n] = now;
						scan_from = n;
						break;
					end
					n = (n == POOL_SLOTS - 1) ? 0 : n + 1;
				end
			end
			esa_pkg::CMD_REFRESH: begin
				if (sel < POOL_SLOTS) begin
					slot_stamp[sel] = now;
					slot_used[sel] = 1'b1;
				end
			end
			esa_pkg::CMD_QUERY: begin
				if (sel < POOL_SLOTS && slot_used[sel]) begin
					reply.ok = 1'b1;
					reply.stamp_time = slot_stamp[sel];
				end
			end
			esa_pkg::CMD_RETURN: begin
				if (sel < POOL_SLOTS)
					slot_used[sel] = 1'b0;
			end
		endcase
		return reply;
	endfunction

	function automatic logic [esa_pkg::TIME_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[esa_pkg::TIME_W-1:0];
	endfunction

	task automatic queue_word(input logic [esa_pkg::CMD_W-1:0] cmd,
		input logic [esa_pkg::TIME_W-1:0] now, input logic [esa_pkg::SEL_W-1:0] sel);
		pool_word_t w;
		w.cmd = cmd;
		w.now_time = now;
		w.slot_select = sel;
		words_pending.push_back(w);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (words_pending.size() != 0 || req_ch.valid || replies_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_expiry(input logic [esa_pkg::TIME_W-1:0] age);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= age;
		@(posedge clk);
		cfg_we <= 1'b0;
		expiry_age = age;
	endtask

	// sender: bursts of words, mostly separated by gaps
	int burst_left = 1;
	int gap_left = 0;
	pool_word_t next_word;

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			replies_due.push_back(pool_response(req_ch.cmd, req_ch.now_time,
				req_ch.slot_select));
		if (!req_ch.valid || req_ch.ready) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (words_pending.size() != 0) begin
				next_word = words_pending.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= next_word.cmd;
				req_ch.now_time <= next_word.now_time;
				req_ch.slot_select <= next_word.slot_select;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: check each word, stall on a randomly chosen pattern
	int stall_tick = 0;
	int stall_mode = 0;
	pool_reply_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected word: ok %0d slot_index %0d", rsp_ch.ok, rsp_ch.slot_index);
				mismatch_count++;
			end else begin
				want = replies_due.pop_front();
				if (rsp_ch.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
					mismatch_count++;
				end
				if (rsp_ch.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index,
						rsp_ch.slot_index);
					mismatch_count++;
				end
				if (rsp_ch.reclaimed !== want.reclaimed) begin
					$error("reclaimed: expected %0d, got %0d", want.reclaimed,
						rsp_ch.reclaimed);
					mismatch_count++;
				end
				if (rsp_ch.stamp_time !== want.stamp_time) begin
					$error("stamp_time: expected %0h, got %0h", want.stamp_time,
						rsp_ch.stamp_time);
					mismatch_count++;
				end
			end
		end
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= (stall_tick % 3 == 0);
			2: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (stall_tick % 16 == 0);
		endcase
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [esa_pkg::TIME_W-1:0] phase_age [5];
		logic [esa_pkg::TIME_W-1:0] now_cursor;
		logic [esa_pkg::TIME_W-1:0] fill_base;
		logic [esa_pkg::CMD_W-1:0]  c;
		logic [esa_pkg::SEL_W-1:0]  s;
		int unsigned                borrow_mark;
		int unsigned                step_cap;
		int                         r;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = esa_pkg::CMD_BORROW;
		req_ch.now_time = '0;
		req_ch.slot_select = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			slot_stamp[i] = '0;
			slot_used[i] = 1'b0;
		end
		scan_from = 0;
		expiry_age = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		queue_word(esa_pkg::CMD_BORROW, '0, '0);
		queue_word(esa_pkg::CMD_BORROW, '0, SEL_TOP);
		queue_word(esa_pkg::CMD_BORROW, 48'd7, '0);
		queue_word(esa_pkg::CMD_QUERY, '0, '0);
		queue_word(esa_pkg::CMD_QUERY, STAMP_TOP, 16'd1);
		queue_word(esa_pkg::CMD_QUERY, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_QUERY, '0, PAST_LAST);
		queue_word(esa_pkg::CMD_QUERY, '0, SEL_TOP);
		queue_word(esa_pkg::CMD_REFRESH, STAMP_TOP, LAST_SLOT);
		queue_word(esa_pkg::CMD_QUERY, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_REFRESH, 48'd5, PAST_LAST);
		queue_word(esa_pkg::CMD_REFRESH, 48'd5, SEL_TOP);
		queue_word(esa_pkg::CMD_QUERY, '0, PAST_LAST);
		queue_word(esa_pkg::CMD_BORROW, STAMP_TOP, '0);
		queue_word(esa_pkg::CMD_RETURN, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_RETURN, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_RETURN, STAMP_TOP, SEL_TOP);
		queue_word(esa_pkg::CMD_RETURN, '0, PAST_LAST);
		queue_word(esa_pkg::CMD_QUERY, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_REFRESH, 48'd12345, 16'd2);
		queue_word(esa_pkg::CMD_QUERY, '0, 16'd2);
		queue_word(esa_pkg::CMD_BORROW, 48'd3, '0);
		queue_word(esa_pkg::CMD_QUERY, '0, 16'd3);
		wait_drained();

		phase_age[0] = 48'd25;
		phase_age[1] = 48'd300;
		phase_age[2] = rand48();
		phase_age[3] = 48'd1;
		phase_age[4] = '0;
		now_cursor = 48'd1000;
		borrow_mark = 4;
		for (int p = 0; p < 5; p++) begin
			write_expiry(phase_age[p]);
			step_cap = (phase_age[p] > 48'd32000) ? 4096
				: 32'((phase_age[p] >> 3) + 48'd3);
			for (int i = 0; i < 20; i++) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					now_cursor = rand48();
				else if (r < 7)
					now_cursor = STAMP_TOP;
				else if (r < 8)
					now_cursor = '0;
				else
					now_cursor = now_cursor + $urandom_range(0, step_cap);
				r = $urandom_range(0, 99);
				if (r < 40)
					s = esa_pkg::SEL_W'((borrow_mark + POOL_SLOTS - $urandom_range(0, 15))
						% POOL_SLOTS);
				else if (r < 75)
					s = esa_pkg::SEL_W'($urandom_range(0, POOL_SLOTS - 1));
				else if (r < 92)
					s = esa_pkg::SEL_W'($urandom_range(POOL_SLOTS, 65535));
				else begin
					case ($urandom_range(0, 3))
						0: s = '0;
						1: s = LAST_SLOT;
						2: s = PAST_LAST;
						default: s = SEL_TOP;
					endcase
				end
				r = $urandom_range(0, 99);
				if (r < 40) begin
					c = esa_pkg::CMD_BORROW;
					borrow_mark++;
				end else if (r < 55)
					c = esa_pkg::CMD_REFRESH;
				else if (r < 80)
					c = esa_pkg::CMD_QUERY;
				else
					c = esa_pkg::CMD_RETURN;
				queue_word(c, now_cursor, s);
			end
			wait_drained();
		end

		// fill the pool so that every slot is young
		write_expiry(STAMP_TOP);
		fill_base = rand48() >> 8;
		for (int i = 0; i < POOL_SLOTS; i++)
			queue_word(esa_pkg::CMD_REFRESH, fill_base + i, esa_pkg::SEL_W'(i));
		queue_word(esa_pkg::CMD_QUERY, '0, '0);
		queue_word(esa_pkg::CMD_QUERY, '0, LAST_SLOT);
		queue_word(esa_pkg::CMD_BORROW, STAMP_TOP, SEL_TOP);
		queue_word(esa_pkg::CMD_BORROW, fill_base + 48'd5000, '0);
		queue_word(esa_pkg::CMD_BORROW, rand48(), esa_pkg::SEL_W'($urandom_range(0, 65535)));
		queue_word(esa_pkg::CMD_QUERY, '0, 16'd512);
		wait_drained();

		// reclaim from a full pool
		write_expiry(48'd600);
		for (int i = 0; i < 20; i++) begin
			now_cursor = fill_base + 48'd800 + $urandom_range(0, 600);
			if ($urandom_range(0, 2) != 0)
				queue_word(esa_pkg::CMD_BORROW, now_cursor,
					esa_pkg::SEL_W'($urandom_range(0, 65535)));
			else
				queue_word(esa_pkg::CMD_QUERY, now_cursor,
					esa_pkg::SEL_W'($urandom_range(0, POOL_SLOTS - 1)));
		end
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
